// File: design/lhc_pkg.sv
// Shared types and constants for the latency histogram collector.
// Holds the command codes, bin edges in nanoseconds and the internal operation word.
// No dependencies.
package lhc_pkg;

   localparam int NUM_BINS          = 10;
   localparam int NUM_EDGES         = NUM_BINS - 1;
   localparam int BIN_W             = 4;
   localparam int LAT_W             = 40;
   localparam int CMD_W             = 2;
   localparam int OUT_COUNT_W       = 48;
   localparam int SUM_W             = 64;
   localparam int COUNT_WIDTH_DEF   = 48;

   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

   localparam logic [CMD_W-1:0] CMD_RECORD   = 2'd0;
   localparam logic [CMD_W-1:0] CMD_READ     = 2'd1;
   localparam logic [CMD_W-1:0] CMD_CLEAR    = 2'd2;
   localparam logic [CMD_W-1:0] CMD_RESERVED = 2'd3;

   // Bin edges, already scaled from microseconds to nanoseconds.
   localparam logic [LAT_W-1:0] EDGE_NS [NUM_EDGES] = '{
      40'd10000, 40'd50000, 40'd100000, 40'd250000, 40'd500000,
      40'd1000000, 40'd5000000, 40'd10000000, 40'd50000000
   };

   typedef enum logic [1:0] {
      OP_RECORD = 2'd0,
      OP_READ   = 2'd1,
      OP_CLEAR  = 2'd2
   } op_kind_type;

   typedef struct packed {
      op_kind_type       kind;
      logic [BIN_W-1:0]  bin;
      logic [LAT_W-1:0]  sample_ns;
   } op_type;

endpackage

// File: design/latency_histogram_collector.sv
// Latency histogram collector: sorts nanosecond latency samples into ten fixed bins.
// Top level; instantiates lhc_front, lhc_queue and lhc_back, depends on lhc_pkg.
//
// Each request word carries a command (record, read, clear), a 40-bit latency
// and a bin select. Every request produces exactly one response word with the
// bin touched, that bin's count, the total sample count and the latency sum in
// nanoseconds; all counters saturate. Commands are sorted into bins by the
// front end and written into a two-word queue; the back end updates the
// counters and loads the response register.
// A request is written into a queue entry and then into the result register
// before its response appears. One request per cycle is sustained while
// rsp_ready stays high; the single read-modify-write of the bin counter in the
// back end sets that rate. Reset clears every counter, the queue and the
// response valid flag at once, and the block takes requests once reset ends.
// When the receiver holds rsp_ready low the response stays put, the queue fills,
// and req_ready drops once both queue entries are in use.
module latency_histogram_collector
   import lhc_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  logic [CMD_W-1:0]       req_cmd,
   input  logic [LAT_W-1:0]       req_sample_ns,
   input  logic [BIN_W-1:0]       req_bin_select,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [BIN_W-1:0]       rsp_bin_index,
   output logic [OUT_COUNT_W-1:0] rsp_bin_count,
   output logic [OUT_COUNT_W-1:0] rsp_sample_count,
   output logic [SUM_W-1:0]       rsp_latency_sum_ns
);

   logic   queue_full;
   logic   push;
   op_type push_op;
   logic   pop_valid;
   op_type pop_op;
   logic   pop;

   lhc_front u_front (
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_cmd        (req_cmd),
      .req_sample_ns  (req_sample_ns),
      .req_bin_select (req_bin_select),
      .queue_full     (queue_full),
      .push           (push),
      .push_op        (push_op)
   );

   lhc_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (push),
      .push_op   (push_op),
      .full      (queue_full),
      .pop_valid (pop_valid),
      .pop_op    (pop_op),
      .pop       (pop)
   );

   lhc_back #(
      .COUNT_WIDTH (COUNT_WIDTH)
   ) u_back (
      .clock              (clock),
      .reset              (reset),
      .op_valid           (pop_valid),
      .op                 (pop_op),
      .op_pop             (pop),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_bin_index      (rsp_bin_index),
      .rsp_bin_count      (rsp_bin_count),
      .rsp_sample_count   (rsp_sample_count),
      .rsp_latency_sum_ns (rsp_latency_sum_ns)
   );

endmodule

// File: design/lhc_front.sv
// Front end of the latency histogram collector: accepts request words and
// classifies them into bin operations. Depends on lhc_pkg.
module lhc_front
   import lhc_pkg::*;
(
   input  logic             req_valid,
   output logic             req_ready,
   input  logic [CMD_W-1:0] req_cmd,
   input  logic [LAT_W-1:0] req_sample_ns,
   input  logic [BIN_W-1:0] req_bin_select,
   input  logic             queue_full,
   output logic             push,
   output op_type           push_op
);

   logic [BIN_W-1:0] sample_bin;
   logic [BIN_W-1:0] read_bin;

   // The edges are increasing, so the number of edges at or below the sample is its bin.
   always_comb begin
      sample_bin = '0;
      for (int i = 0; i < NUM_EDGES; i++) begin
         sample_bin = sample_bin + BIN_W'(req_sample_ns >= EDGE_NS[i]);
      end
   end

   assign read_bin = (req_bin_select >= BIN_W'(NUM_BINS)) ? BIN_W'(NUM_BINS - 1)
                                                          : req_bin_select;

   always_comb begin
      push_op.sample_ns = req_sample_ns;
      unique case (req_cmd) inside
         CMD_RECORD: begin
            push_op.kind = OP_RECORD;
            push_op.bin  = sample_bin;
         end
         CMD_CLEAR: begin
            push_op.kind = OP_CLEAR;
            push_op.bin  = '0;
         end
         CMD_READ, CMD_RESERVED: begin
            push_op.kind = OP_READ;
            push_op.bin  = read_bin;
         end
         default: begin
            push_op.kind = OP_READ;
            push_op.bin  = read_bin;
         end
      endcase
   end

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

endmodule

// File: design/lhc_queue.sv
// Short operation queue between the front and back ends of the collector.
// Depends on lhc_pkg for the operation word and the queue depth.
module lhc_queue
   import lhc_pkg::*;
(
   input  logic   clock,
   input  logic   reset,
   input  logic   push,
   input  op_type push_op,
   output logic   full,
   output logic   pop_valid,
   output op_type pop_op,
   input  logic   pop
);

   op_type              entries_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;

   assign full      = (count_ff == QCNT_W'(QUEUE_DEPTH));
   assign pop_valid = (count_ff != '0);
   assign pop_op    = entries_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (push) begin
         wr_ptr_in = (wr_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr_ff + 1'b1;
      end
      if (pop) begin
         rd_ptr_in = (rd_ptr_ff == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr_ff + 1'b1;
      end
      if (push && !pop) begin
         count_in = count_ff + 1'b1;
      end else if (pop && !push) begin
         count_in = count_ff - 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         entries_ff[wr_ptr_ff] <= push_op;
      end
   end

   a_count_bounded: assert property (@(posedge clock) disable iff (reset)
      count_ff <= QCNT_W'(QUEUE_DEPTH))
      else $error("queue fill count exceeds its depth");

   a_no_pop_empty: assert property (@(posedge clock) disable iff (reset)
      pop |-> pop_valid)
      else $error("queue popped while empty");

   a_full_blocks_push: assert property (@(posedge clock) disable iff (reset)
      full |-> !push)
      else $error("queue written while full");

endmodule

// File: design/lhc_back.sv
// Back end of the latency histogram collector: bin counters, sample count,
// latency sum and the result register. Depends on lhc_pkg.
module lhc_back
   import lhc_pkg::*;
#(
   parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
)
(
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   op_valid,
   input  op_type                 op,
   output logic                   op_pop,
   output logic                   rsp_valid,
   input  logic                   rsp_ready,
   output logic [BIN_W-1:0]       rsp_bin_index,
   output logic [OUT_COUNT_W-1:0] rsp_bin_count,
   output logic [OUT_COUNT_W-1:0] rsp_sample_count,
   output logic [SUM_W-1:0]       rsp_latency_sum_ns
);

   logic [COUNT_WIDTH-1:0] bin_counts_ff [NUM_BINS];
   logic [COUNT_WIDTH-1:0] bin_counts_in [NUM_BINS];
   logic [COUNT_WIDTH-1:0] samples_ff, samples_in;
   logic [SUM_W-1:0]       total_ff, total_in;

   logic                   rsp_valid_ff, rsp_valid_in;
   logic [BIN_W-1:0]       rsp_bin_ff;
   logic [OUT_COUNT_W-1:0] rsp_count_ff, rsp_count_in;
   logic [OUT_COUNT_W-1:0] rsp_samples_ff, rsp_samples_in;
   logic [SUM_W-1:0]       rsp_sum_ff;

   logic [COUNT_WIDTH-1:0] cur_count;
   logic [COUNT_WIDTH-1:0] cur_count_inc;
   logic [COUNT_WIDTH-1:0] samples_inc;
   logic [SUM_W:0]         sum_wide;
   logic [SUM_W-1:0]       sum_sat;
   logic [COUNT_WIDTH-1:0] res_count;
   logic [63:0]            res_count_ext;
   logic [63:0]            res_samples_ext;

   // A new word enters when the result register is empty or being drained.
   assign op_pop = op_valid && (!rsp_valid_ff || rsp_ready);

   assign cur_count     = bin_counts_ff[op.bin];
   assign cur_count_inc = (cur_count == '1) ? cur_count : cur_count + 1'b1;
   assign samples_inc   = (samples_ff == '1) ? samples_ff : samples_ff + 1'b1;
   assign sum_wide      = {1'b0, total_ff} + (SUM_W + 1)'(op.sample_ns);
   assign sum_sat       = sum_wide[SUM_W] ? '1 : sum_wide[SUM_W-1:0];

   always_comb begin
      bin_counts_in = bin_counts_ff;
      samples_in    = samples_ff;
      total_in      = total_ff;
      res_count     = cur_count;
      unique case (op.kind)
         OP_RECORD: begin
            bin_counts_in[op.bin] = cur_count_inc;
            samples_in            = samples_inc;
            total_in              = sum_sat;
            res_count             = cur_count_inc;
         end
         OP_CLEAR: begin
            for (int i = 0; i < NUM_BINS; i++) begin
               bin_counts_in[i] = '0;
            end
            samples_in = '0;
            total_in   = '0;
            res_count  = '0;
         end
         OP_READ: begin
            res_count = cur_count;
         end
         default: begin
            res_count = cur_count;
         end
      endcase
   end

   // Result fields carry the low 48 bits of each counter.
   assign res_count_ext   = 64'(res_count);
   assign res_samples_ext = 64'(samples_in);
   assign rsp_count_in    = res_count_ext[OUT_COUNT_W-1:0];
   assign rsp_samples_in  = res_samples_ext[OUT_COUNT_W-1:0];

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (op_pop) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < NUM_BINS; i++) begin
            bin_counts_ff[i] <= '0;
         end
         samples_ff   <= '0;
         total_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         if (op_pop) begin
            bin_counts_ff <= bin_counts_in;
            samples_ff    <= samples_in;
            total_ff      <= total_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (op_pop) begin
         rsp_bin_ff     <= op.bin;
         rsp_count_ff   <= rsp_count_in;
         rsp_samples_ff <= rsp_samples_in;
         rsp_sum_ff     <= total_in;
      end
   end

   assign rsp_valid          = rsp_valid_ff;
   assign rsp_bin_index      = rsp_bin_ff;
   assign rsp_bin_count      = rsp_count_ff;
   assign rsp_sample_count   = rsp_samples_ff;
   assign rsp_latency_sum_ns = rsp_sum_ff;

   a_clear_zeroes: assert property (@(posedge clock) disable iff (reset)
      (op_pop && op.kind == OP_CLEAR) |=> (samples_ff == '0 && total_ff == '0))
      else $error("clear left the sample count or sum nonzero");

   a_record_counts: assert property (@(posedge clock) disable iff (reset)
      (op_pop && op.kind == OP_RECORD && samples_ff != '1)
      |=> samples_ff == $past(samples_ff) + 1'b1)
      else $error("record did not advance the sample count");

   a_sum_monotonic: assert property (@(posedge clock) disable iff (reset)
      (op_pop && op.kind != OP_CLEAR) |=> total_ff >= $past(total_ff))
      else $error("latency sum decreased without a clear");

   a_read_static: assert property (@(posedge clock) disable iff (reset)
      (op_pop && op.kind == OP_READ) |=> $stable(samples_ff) && $stable(total_ff))
      else $error("read changed the histogram state");

endmodule

// File: tb/tb_latency_histogram_collector.sv
// Testbench for latency_histogram_collector: directed bin-edge cases, then random
// record, read and clear traffic with random stalls on both channels, checked word
// by word against a scoreboard that tracks the bins, sample count and sum. Uses lhc_pkg.
module tb_latency_histogram_collector;
   import lhc_pkg::*;

   localparam int STALL_LIMIT  = 2000;
   localparam int RANDOM_WORDS = 400;
   localparam int DRAIN_CYCLES = 20;
   localparam int LONG_HOLD    = 100;
   localparam longint unsigned EDGE_US [NUM_EDGES] = '{
      10, 50, 100, 250, 500, 1000, 5000, 10000, 50000
   };
   localparam longint unsigned LAT_MAX = (64'd1 << LAT_W) - 1;

   typedef struct packed {
      logic [BIN_W-1:0]       bin;
      logic [OUT_COUNT_W-1:0] bin_count;
      logic [OUT_COUNT_W-1:0] samples;
      logic [SUM_W-1:0]       sum;
   } hist_word_type;

   // Tracks the histogram state and holds the responses still owed by the block.
   class hist_scoreboard;
      logic [COUNT_WIDTH_DEF-1:0] bin_tally [NUM_BINS];
      logic [COUNT_WIDTH_DEF-1:0] sample_tally;
      logic [SUM_W-1:0]           ns_sum;
      hist_word_type              awaited [$];
      int failures, checked, records, reads, reserved_reads, clears;

      function new();
         clear_all();
      endfunction

      function void clear_all();
         foreach (bin_tally[i]) bin_tally[i] = '0;
         sample_tally = '0;
         ns_sum       = '0;
      endfunction

      function void note_word(logic [CMD_W-1:0] cmd, logic [LAT_W-1:0] ns,
                              logic [BIN_W-1:0] sel);
         int unsigned     b;
         logic [SUM_W:0]  wide_sum;
         hist_word_type   w;
         b = 0;
         case (cmd)
            CMD_RECORD: begin
               // A sample at or above an edge moves past that bin.
               while (b < NUM_EDGES && 64'(ns) >= EDGE_US[b] * 1000) b++;
               if (bin_tally[b] != '1) bin_tally[b] = bin_tally[b] + 1'b1;
               if (sample_tally != '1) sample_tally = sample_tally + 1'b1;
               wide_sum = {1'b0, ns_sum} + (SUM_W + 1)'(ns);
               ns_sum   = wide_sum[SUM_W] ? '1 : wide_sum[SUM_W-1:0];
               records++;
            end
            CMD_CLEAR: begin
               clear_all();
               clears++;
            end
            default: begin
               // The unused code answers like a read; selects past the last bin clamp.
               b = (sel >= NUM_BINS) ? NUM_BINS - 1 : sel;
               if (cmd == CMD_READ) reads++;
               else reserved_reads++;
            end
         endcase
         w.bin       = BIN_W'(b);
         w.bin_count = OUT_COUNT_W'(bin_tally[b]);
         w.samples   = OUT_COUNT_W'(sample_tally);
         w.sum       = ns_sum;
         awaited.insert(awaited.size(), w);
      endfunction

      function void check_word(hist_word_type got);
         hist_word_type want;
         checked++;
         if (awaited.size() == 0) begin
            $error("response word with no request outstanding, bin_index %0d", got.bin);
            failures++;
            return;
         end
         want = awaited.pop_front();
         if (got.bin !== want.bin) begin
            $error("bin_index: expected %0d, actual %0d", want.bin, got.bin);
            failures++;
         end
         if (got.bin_count !== want.bin_count) begin
            $error("bin_count: expected %0d, actual %0d", want.bin_count, got.bin_count);
            failures++;
         end
         if (got.samples !== want.samples) begin
            $error("sample_count: expected %0d, actual %0d", want.samples, got.samples);
            failures++;
         end
         if (got.sum !== want.sum) begin
            $error("latency_sum_ns: expected %0d, actual %0d", want.sum, got.sum);
            failures++;
         end
      endfunction
   endclass

   logic                   clock;
   logic                   reset;
   logic                   req_valid;
   logic                   req_ready;
   logic [CMD_W-1:0]       req_cmd;
   logic [LAT_W-1:0]       req_sample_ns;
   logic [BIN_W-1:0]       req_bin_select;
   logic                   rsp_valid;
   logic                   rsp_ready;
   logic [BIN_W-1:0]       rsp_bin_index;
   logic [OUT_COUNT_W-1:0] rsp_bin_count;
   logic [OUT_COUNT_W-1:0] rsp_sample_count;
   logic [SUM_W-1:0]       rsp_latency_sum_ns;

   hist_scoreboard tracker;
   int             stall_cycles;
   bit             req_no_idle;
   bit             rsp_no_idle;

   latency_histogram_collector u_top (
      .clock              (clock),
      .reset              (reset),
      .req_valid          (req_valid),
      .req_ready          (req_ready),
      .req_cmd            (req_cmd),
      .req_sample_ns      (req_sample_ns),
      .req_bin_select     (req_bin_select),
      .rsp_valid          (rsp_valid),
      .rsp_ready          (rsp_ready),
      .rsp_bin_index      (rsp_bin_index),
      .rsp_bin_count      (rsp_bin_count),
      .rsp_sample_count   (rsp_sample_count),
      .rsp_latency_sum_ns (rsp_latency_sum_ns)
   );

   initial clock = 1'b0;
   always #5 clock = ~clock;

   // Each side now and then switches between random gaps and running flat out.
   function automatic int draw_gap(inout bit no_idle);
      if ($urandom_range(0, 24) == 0) no_idle = !no_idle;
      return no_idle ? 0 : $urandom_range(0, 14);
   endfunction

   task automatic send_word(logic [CMD_W-1:0] cmd, logic [LAT_W-1:0] ns,
                            logic [BIN_W-1:0] sel);
      int gap;
      gap = draw_gap(req_no_idle);
      @(negedge clock);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_valid      <= 1'b1;
      req_cmd        <= cmd;
      req_sample_ns  <= ns;
      req_bin_select <= sel;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      tracker.note_word(cmd, ns, sel);
   endtask

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) stall_cycles <= 0;
      else stall_cycles <= stall_cycles + 1;
   end

   initial begin
      @(negedge reset);
      while (stall_cycles < STALL_LIMIT) @(posedge clock);
      $display("simulation failed");
      $finish;
   end

   // Response side: random stalls, plus two long holds that back the block up.
   initial begin
      int gap;
      rsp_ready = 1'b0;
      @(negedge reset);
      forever begin
         gap = draw_gap(rsp_no_idle);
         if (tracker.checked == 120 || tracker.checked == 300) gap = LONG_HOLD;
         @(negedge clock);
         if (gap > 0) begin
            rsp_ready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         @(posedge clock);
         while (!rsp_valid) @(posedge clock);
         tracker.check_word({rsp_bin_index, rsp_bin_count, rsp_sample_count,
                             rsp_latency_sum_ns});
      end
   end

   initial begin
      logic [CMD_W-1:0]  cmd;
      logic [LAT_W-1:0]  ns;
      longint unsigned   lo, hi;
      int unsigned       b, roll;

      tracker        = new();
      reset          = 1'b1;
      req_valid      = 1'b0;
      req_cmd        = CMD_RECORD;
      req_sample_ns  = '0;
      req_bin_select = '0;
      repeat (6) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // Directed: both sides of every bin edge, the extremes and the odd selects.
      send_word(CMD_RECORD, '0, 4'd0);
      for (int i = 0; i < NUM_EDGES; i++) begin
         send_word(CMD_RECORD, LAT_W'(EDGE_US[i] * 1000 - 1), 4'd5);
         send_word(CMD_RECORD, LAT_W'(EDGE_US[i] * 1000), 4'd10);
      end
      send_word(CMD_RECORD, '1, 4'd15);
      send_word(CMD_READ, '0, 4'd15);
      send_word(CMD_READ, '1, 4'd10);
      send_word(CMD_RESERVED, '0, 4'd12);
      send_word(CMD_CLEAR, '1, 4'd7);
      send_word(CMD_RESERVED, '1, 4'd9);

      for (int n = 0; n < RANDOM_WORDS; n++) begin
         roll = $urandom_range(0, 99);
         if (roll < 70) cmd = CMD_RECORD;
         else if (roll < 90) cmd = CMD_READ;
         else if (roll < 96) cmd = CMD_RESERVED;
         else cmd = CMD_CLEAR;
         b  = $urandom_range(0, NUM_BINS - 1);
         lo = (b == 0) ? 0 : EDGE_US[b-1] * 1000;
         hi = (b == NUM_BINS - 1) ? LAT_MAX : EDGE_US[b] * 1000 - 1;
         case ($urandom_range(0, 3))
            0: ns = LAT_W'({$urandom, $urandom});
            1: ns = LAT_W'(lo + $urandom_range(0, 3));
            2: ns = LAT_W'(hi - $urandom_range(0, 3));
            default: ns = LAT_W'(lo + ({$urandom, $urandom} % (hi - lo + 1)));
         endcase
         send_word(cmd, ns, 4'($urandom_range(0, 15)));
      end
      @(negedge clock);
      req_valid <= 1'b0;

      while (tracker.awaited.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);

      $display("Checked %0d response words: %0d samples recorded, %0d bin reads,",
               tracker.checked, tracker.records, tracker.reads);
      $display("%0d reads on the unused command code and %0d clears, with random stalls.",
               tracker.reserved_reads, tracker.clears);
      if (tracker.failures == 0 && tracker.awaited.size() == 0)
         $display("simulation ok");
      else
         $display("simulation failed");
      $finish;
   end

endmodule
